/* rtl/core/ler_pkg.sv */
// ----------------------------------------------------------------------------
// ler_pkg
// Shared types, constants and pointer helpers for the line edit input ring.
// ----------------------------------------------------------------------------
package ler_pkg;

   localparam int RING_DEPTH  = 1024;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);
   localparam int LINES_W     = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_RX     = 2'd0;
   localparam logic [1:0] CMD_FETCH  = 2'd1;
   localparam logic [1:0] CMD_HANGUP = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   localparam logic [7:0] CH_BS       = 8'd8;
   localparam logic [7:0] CH_LF       = 8'd10;
   localparam logic [7:0] CH_CR       = 8'd13;
   localparam logic [7:0] CH_CTRL_MAX = 8'd31;
   localparam logic [7:0] CH_DEL      = 8'd127;
   localparam logic [7:0] CH_HIGH     = 8'h80;
   localparam logic [7:0] CH_CSI      = 8'd155;
   localparam logic [7:0] CH_IAC      = 8'd255;
   localparam logic [7:0] CH_DO       = 8'd253;
   localparam logic [7:0] CH_DONT     = 8'd254;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STORE,
      OP_ERASE,
      OP_FETCH,
      OP_HANGUP
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       is_lf;
      logic       intr_load;
      logic       intr_val;
   } item_type;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      next_pos = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p);
      prev_pos = (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - PTR_W'(1);
   endfunction

endpackage

/* rtl/core/ler_front.sv */
// ----------------------------------------------------------------------------
// ler_front
// Accepts request words, decodes the command and filters received bytes.
// ----------------------------------------------------------------------------
module ler_front
   import ler_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_rx_byte,
   input  logic       req_last_of_read,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic keep;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   assign keep = (req_rx_byte > CH_CTRL_MAX && req_rx_byte < CH_DEL)
              || (req_rx_byte >= CH_HIGH && req_rx_byte != CH_CSI)
              || (req_rx_byte == CH_LF);

   always_comb begin
      q_item.data      = req_rx_byte;
      q_item.is_lf     = (req_rx_byte == CH_LF);
      q_item.intr_load = 1'b0;
      q_item.intr_val  = (req_rx_byte == CH_LF) || (req_rx_byte == CH_CR);
      q_item.op        = OP_NONE;
      unique case (req_cmd)
         CMD_RX: begin
            q_item.intr_load = req_last_of_read;
            if (req_rx_byte == CH_BS || req_rx_byte == CH_DEL) begin
               q_item.op = OP_ERASE;
            end else if (keep) begin
               q_item.op = OP_STORE;
            end else begin
               q_item.op = OP_NONE;
            end
         end
         CMD_FETCH:  q_item.op = OP_FETCH;
         CMD_HANGUP: q_item.op = OP_HANGUP;
         CMD_NONE:   q_item.op = OP_NONE;
      endcase
   end

endmodule

/* rtl/core/ler_queue.sv */
// ----------------------------------------------------------------------------
// ler_queue
// Short word queue between the decode front and the ring engine.
// ----------------------------------------------------------------------------
module ler_queue
   import ler_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type pop_item,
   output logic     full,
   output logic     not_empty
);

   item_type             slot_ff [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0]   wr_idx_ff;
   logic [Q_IDX_W-1:0]   rd_idx_ff;
   logic [Q_CNT_W-1:0]   count_ff;

   assign full      = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_idx_ff <= wr_idx_ff + Q_IDX_W'(1);
         end
         if (pop) begin
            rd_idx_ff <= rd_idx_ff + Q_IDX_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/ler_back.sv */
// ----------------------------------------------------------------------------
// ler_back
// Ring engine: byte ring memory, pointers, line count, flags, result register.
// ----------------------------------------------------------------------------
module ler_back
   import ler_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_line_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_line_end,
   output logic [LINES_W-1:0] rsp_lines_pending,
   output logic               rsp_interrupt_flag,
   output logic               rsp_link_dropped,
   output logic               rsp_ring_empty
);

   typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SKIP} state_type;

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] lc_ff, lc_in;
   logic             mid_ff, mid_in;
   logic             intr_ff, intr_in;
   logic             drop_ff, drop_in;

   logic             rsp_valid_ff;
   logic [7:0]       line_byte_ff;
   logic             byte_valid_ff;
   logic             line_end_ff;

   logic [7:0]       byte_ring_ff [RING_DEPTH];
   logic [7:0]       rd_a_ff;
   logic [7:0]       rd_b_ff;

   logic             free;
   logic             emit;
   logic             emit_valid;
   logic             emit_end;
   logic [7:0]       emit_byte;
   logic             mem_we;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr_a;
   logic [PTR_W-1:0] nx_rp;
   logic [PTR_W-1:0] nx2_rp;
   logic [PTR_W-1:0] nx_wp;
   logic [CNT_W-1:0] lc_dec;
   logic             empty;
   logic             at_start;
   logic             telnet_pair;

   assign free     = !rsp_valid_ff || !rsp_stall;
   assign nx_rp    = next_pos(rp_ff);
   assign nx2_rp   = next_pos(nx_rp);
   assign nx_wp    = next_pos(wp_ff);
   assign lc_dec   = (lc_ff != '0) ? lc_ff - CNT_W'(1) : lc_ff;
   assign empty    = (wp_ff == rp_ff);
   assign at_start = !mid_ff;
   assign telnet_pair = at_start && rd_a_ff == CH_IAC && nx_rp != wp_ff
                     && (rd_b_ff == CH_DO || rd_b_ff == CH_DONT);

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      lc_in      = lc_ff;
      mid_in     = mid_ff;
      intr_in    = intr_ff;
      drop_in    = drop_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      emit_valid = 1'b0;
      emit_end   = 1'b0;
      emit_byte  = '0;
      mem_we     = 1'b0;
      rd_en      = 1'b0;
      rd_addr_a  = rp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && free) begin
               q_pop = 1'b1;
               if (q_item.intr_load) begin
                  intr_in = q_item.intr_val;
               end
               unique case (q_item.op)
                  OP_STORE: begin
                     emit   = 1'b1;
                     mem_we = 1'b1;
                     wp_in  = nx_wp;
                     if (nx_wp == rp_ff) begin
                        rp_in = nx_rp;
                     end
                     if (q_item.is_lf && lc_ff < CNT_W'(RING_DEPTH)) begin
                        lc_in = lc_ff + CNT_W'(1);
                     end
                  end
                  OP_ERASE: begin
                     emit = 1'b1;
                     if (!empty) begin
                        wp_in = prev_pos(wp_ff);
                     end
                  end
                  OP_HANGUP: begin
                     emit    = 1'b1;
                     drop_in = 1'b1;
                  end
                  OP_FETCH: begin
                     if (at_start && (lc_ff == '0 || empty)) begin
                        emit = 1'b1;
                     end else if (!at_start && empty) begin
                        emit     = 1'b1;
                        emit_end = 1'b1;
                        lc_in    = lc_dec;
                        mid_in   = 1'b0;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         S_FETCH: begin
            if (free) begin
               if (telnet_pair) begin
                  rp_in  = nx2_rp;
                  mid_in = 1'b1;
                  if (nx2_rp == wp_ff) begin
                     emit     = 1'b1;
                     emit_end = 1'b1;
                     lc_in    = lc_dec;
                     mid_in   = 1'b0;
                     state_in = S_IDLE;
                  end else begin
                     rd_en     = 1'b1;
                     rd_addr_a = nx2_rp;
                     state_in  = S_SKIP;
                  end
               end else begin
                  emit     = 1'b1;
                  rp_in    = nx_rp;
                  mid_in   = 1'b1;
                  state_in = S_IDLE;
                  if (rd_a_ff != CH_LF && rd_a_ff != CH_CR) begin
                     emit_valid = 1'b1;
                     emit_byte  = rd_a_ff;
                  end else begin
                     emit_end = 1'b1;
                     lc_in    = lc_dec;
                     mid_in   = 1'b0;
                  end
               end
            end
         end
         S_SKIP: begin
            if (free) begin
               emit     = 1'b1;
               rp_in    = nx_rp;
               mid_in   = 1'b1;
               state_in = S_IDLE;
               if (rd_a_ff != CH_LF && rd_a_ff != CH_CR) begin
                  emit_valid = 1'b1;
                  emit_byte  = rd_a_ff;
               end else begin
                  emit_end = 1'b1;
                  lc_in    = lc_dec;
                  mid_in   = 1'b0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         wp_ff              <= '0;
         rp_ff              <= '0;
         lc_ff              <= '0;
         mid_ff             <= 1'b0;
         intr_ff            <= 1'b0;
         drop_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         rsp_lines_pending  <= '0;
         rsp_interrupt_flag <= 1'b0;
         rsp_link_dropped   <= 1'b0;
         rsp_ring_empty     <= 1'b1;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         lc_ff    <= lc_in;
         mid_ff   <= mid_in;
         intr_ff  <= intr_in;
         drop_ff  <= drop_in;
         if (emit) begin
            rsp_valid_ff       <= 1'b1;
            rsp_lines_pending  <= LINES_W'(lc_in);
            rsp_interrupt_flag <= intr_in;
            rsp_link_dropped   <= drop_in;
            rsp_ring_empty     <= (wp_in == rp_in);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         line_byte_ff  <= emit_byte;
         byte_valid_ff <= emit_valid;
         line_end_ff   <= emit_end;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_ring_ff[wp_ff] <= q_item.data;
      end
      if (rd_en) begin
         rd_a_ff <= byte_ring_ff[rd_addr_a];
         rd_b_ff <= byte_ring_ff[nx_rp];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_byte  = line_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_line_end   = line_end_ff;

endmodule

/* rtl/core/line_edit_input_ring.sv */
// ----------------------------------------------------------------------------
// line_edit_input_ring
// Input ring of a terminal line discipline: filters received bytes, keeps
// them in an overwriting ring and hands out complete lines byte by byte.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  request  | req_cmd, req_rx_byte, req_last_of_read  | req_valid / req_stall
//  response | rsp_line_byte ... rsp_ring_empty        | rsp_valid / rsp_stall
//
//  Received byte, hang-up and idle commands: one word per cycle while the result register is not stalled.
//  Fetch: answered directly when there is nothing to read, otherwise after a
//  registered ring read, and after a second registered read when a telnet pair
//  is skipped at line start and a byte follows it.
//  A four-word queue lets requests be taken while the result register stalls.
//  Synchronous active-high reset; ring contents are not cleared.
// ----------------------------------------------------------------------------
module line_edit_input_ring
   import ler_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_last_of_read,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_line_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_line_end,
   output logic [LINES_W-1:0] rsp_lines_pending,
   output logic               rsp_interrupt_flag,
   output logic               rsp_link_dropped,
   output logic               rsp_ring_empty
);

   item_type push_item;
   item_type pop_item;
   logic     push;
   logic     pop;
   logic     full;
   logic     not_empty;

   ler_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_rx_byte      (req_rx_byte),
      .req_last_of_read (req_last_of_read),
      .q_full           (full),
      .q_push           (push),
      .q_item           (push_item)
   );

   ler_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (full),
      .not_empty (not_empty)
   );

   ler_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (not_empty),
      .q_item             (pop_item),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_line_byte      (rsp_line_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_line_end       (rsp_line_end),
      .rsp_lines_pending  (rsp_lines_pending),
      .rsp_interrupt_flag (rsp_interrupt_flag),
      .rsp_link_dropped   (rsp_link_dropped),
      .rsp_ring_empty     (rsp_ring_empty)
   );

endmodule
